// ===== src/ascii_integer_parser_macros.svh =====
// Assertion helpers for the ASCII integer parser.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aip: same-cycle check failed");
`define AIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aip: next-cycle check failed");
`else
`define AIP_ASSERT_SAME(label, ante, cons)
`define AIP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/aip_pkg.sv =====
`default_nettype none

package aip_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned MagW  = 31;
  localparam int unsigned CntW  = 16;
  localparam int unsigned BaseW = 6;

  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [CntW-1:0]        consumed;
  } res_t;

  typedef struct packed {
    logic             ok;
    logic [BaseW-1:0] val;
  } dig_t;

  // '0'..'9' -> 0..9, letters of either case -> 10..35
  function automatic dig_t digit_of(input logic [7:0] c);
    dig_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ascii_integer_parser.sv =====
// A character transferred into the input stage is parsed once the result slot
// is free; its result, if any, is registered and shown on value_o/consumed_o.
// Throughput: one character per cycle while out_ready_i stays high.
// Reset (rst_ni low, asynchronous): radix goes to 0 (auto-detect), input and
// output stages empty, parser waits for the sign or first character.
`default_nettype none

module ascii_integer_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // radix register write
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [aip_pkg::BaseW-1:0] cfg_data_i,
  // character stream
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                ch_i,
  input  wire logic                      start_req_i,
  // parsed results
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [aip_pkg::ValW-1:0] value_o,
  output logic [aip_pkg::CntW-1:0]       consumed_o
);
  import aip_pkg::*;

  // radix register, always writable
  logic [BaseW-1:0] radix_q;

  // input stage
  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       start_q;

  logic fire;
  logic out_free;
  logic emit;
  res_t res_new;
  res_t res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_data_i;
    end
  end

  // the held character is parsed once the result slot can take a transfer;
  // the parser state loop closes in that same cycle
  assign fire       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q    <= ch_i;
      start_q <= start_req_i;
    end
  end

  // sign / prefix / digit accumulate with 31-bit saturation
  aip_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .ch_i    (ch_q),
    .start_i (start_q),
    .radix_i (radix_q),
    .emit_o  (emit),
    .res_o   (res_new)
  );

  // result register: parts the result handshake from the parser
  aip_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res_new),
    .ready_i (out_ready_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .res_o   (res_out)
  );

  assign value_o    = res_out.value;
  assign consumed_o = res_out.consumed;

endmodule

`default_nettype wire

// ===== src/aip_core.sv =====
`default_nettype none
`include "ascii_integer_parser_macros.svh"

module aip_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      fire_i,
  input  wire logic [7:0]                ch_i,
  input  wire logic                      start_i,
  input  wire logic [aip_pkg::BaseW-1:0] radix_i,
  output logic                           emit_o,
  output aip_pkg::res_t                  res_o
);
  import aip_pkg::*;

  localparam logic [2:0] PhSign   = 3'd0;
  localparam logic [2:0] PhPrefix = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhDigits = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  logic [2:0]       phase_q, phase_d;
  logic [MagW-1:0]  mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [BaseW-1:0] base_q, base_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [2:0]       ph;
  logic [MagW-1:0]  mag;
  logic             neg;
  logic [BaseW-1:0] base;
  logic [CntW-1:0]  cnt;
  logic             took;
  logic             inc;
  logic             emit;
  dig_t             dg;
  logic [36:0]      mul;
  logic [37:0]      acc;

  always_comb begin
    // start request wipes the parse before the char is looked at
    ph   = start_i ? PhSign : phase_q;
    mag  = start_i ? '0 : mag_q;
    neg  = start_i ? 1'b0 : neg_q;
    base = start_i ? '0 : base_q;
    cnt  = start_i ? '0 : cnt_q;

    dg   = digit_of(ch_i);
    took = 1'b0;
    inc  = 1'b0;
    emit = 1'b0;
    mul  = '0;
    acc  = '0;

    phase_d = ph;
    mag_d   = mag;
    neg_d   = neg;
    base_d  = base;

    if (ph == PhDone) begin
      took = 1'b1;
    end else if (ph == PhSign && ch_i == ChMinus) begin
      neg_d   = 1'b1;
      inc     = 1'b1;
      phase_d = PhPrefix;
      took    = 1'b1;
    end else if (ph == PhSign || ph == PhPrefix) begin
      if (radix_i == '0) begin
        if (ch_i == ChZero) begin
          base_d  = BaseW'(8);
          inc     = 1'b1;
          phase_d = PhZero;
          took    = 1'b1;
        end else begin
          base_d = BaseW'(10);
        end
      end else begin
        base_d = radix_i;
      end
    end else if (ph == PhZero) begin
      if (ch_i == ChLowX || ch_i == ChUpX) begin
        base_d  = BaseW'(16);
        inc     = 1'b1;
        phase_d = PhDigits;
        took    = 1'b1;
      end
    end

    if (!took) begin
      phase_d = PhDigits;
      mul = 37'(mag) * 37'(base_d);
      acc = 38'(mul) + 38'(dg.val);
      if (dg.ok && dg.val < base_d) begin
        mag_d = (acc > 38'(MagMax)) ? MagMax : acc[MagW-1:0];
        inc   = 1'b1;
      end else begin
        emit    = 1'b1;
        phase_d = PhDone;
      end
    end

    cnt_d = (inc && cnt != CntMax) ? cnt + 1'b1 : cnt;

    if (!neg) begin
      res_o.value = signed'({1'b0, mag});
    end else if (mag == MagMax) begin
      res_o.value = signed'({1'b1, {MagW{1'b0}}});
    end else begin
      res_o.value = signed'(ValW'(0) - {1'b0, mag});
    end
    res_o.consumed = cnt;
  end

  assign emit_o = fire_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSign;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      base_q  <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
    end
  end

  `AIP_ASSERT_SAME(a_done_silent, fire_i && !start_i && phase_q == PhDone, !emit_o)
  `AIP_ASSERT_NEXT(a_emit_done, emit_o, phase_q == PhDone)
  `AIP_ASSERT_SAME(a_digits_base, phase_q == PhDigits, base_q != '0)

endmodule

`default_nettype wire

// ===== src/aip_out_reg.sv =====
`default_nettype none

module aip_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire aip_pkg::res_t res_i,
  input  wire logic          ready_i,
  output logic               free_o,
  output logic               valid_o,
  output aip_pkg::res_t      res_o
);
  import aip_pkg::*;

  logic vld_q;
  res_t res_q;

  // slot frees up in the same cycle its transfer completes
  assign free_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== test/ascii_integer_parser_checker.sv =====
module ascii_integer_parser_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [aip_pkg::BaseW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [7:0]                       ch_i,
  input  logic                             start_req_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [aip_pkg::ValW-1:0]  value_i,
  input  logic [aip_pkg::CntW-1:0]         consumed_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PhSign,
    PhPrefix,
    PhZero,
    PhDigits,
    PhDone
  } parse_phase_e;

  localparam int unsigned NotDigit = 255;
  localparam logic [aip_pkg::ValW-1:0] ValMin = {1'b1, {(aip_pkg::ValW-1){1'b0}}};

  parse_phase_e                phase;
  logic [aip_pkg::MagW-1:0]    mag;
  logic                        neg;
  logic [aip_pkg::BaseW-1:0]   radix;
  logic [aip_pkg::BaseW-1:0]   base;
  logic [aip_pkg::CntW-1:0]    count;
  aip_pkg::res_t               parsed_q[$];

  initial fail_count_o = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] parser mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic int unsigned digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    if (c >= "a" && c <= "z") return c - "a" + 10;
    return NotDigit;
  endfunction

  task automatic clear_parse();
    phase = PhSign;
    mag   = '0;
    neg   = 1'b0;
    base  = '0;
    count = '0;
  endtask

  task automatic bump_count();
    if (count != aip_pkg::CntMax) count++;
  endtask

  // one accepted character; pushes the parsed value when it stops the number
  task automatic parse_char(logic [7:0] c, logic first);
    int unsigned   d;
    logic [63:0]   acc;
    aip_pkg::res_t res;
    if (first) clear_parse();
    if (phase == PhDone) return;
    if (phase == PhSign) begin
      phase = PhPrefix;
      if (c == "-") begin
        neg = 1'b1;
        bump_count();
        return;
      end
    end
    if (phase == PhPrefix) begin
      phase = PhDigits;
      if (radix != '0) begin
        base = radix;
      end else if (c == "0") begin
        base  = 6'd8;
        phase = PhZero;
        bump_count();
        return;
      end else begin
        base = 6'd10;
      end
    end else if (phase == PhZero) begin
      phase = PhDigits;
      if (c == "x" || c == "X") begin
        base = 6'd16;
        bump_count();
        return;
      end
    end
    d = digit_value(c);
    if (d < base) begin
      acc = 64'(mag) * 64'(base) + 64'(d);
      mag = (acc > 64'(aip_pkg::MagMax)) ? aip_pkg::MagMax : acc[aip_pkg::MagW-1:0];
      bump_count();
      return;
    end
    if (!neg) res.value = 32'(mag);
    else if (mag == aip_pkg::MagMax) res.value = ValMin;
    else res.value = 32'(0) - 32'(mag);
    res.consumed = count;
    parsed_q.push_back(res);
    phase = PhDone;
  endtask

  task automatic check_result();
    aip_pkg::res_t want;
    if (parsed_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: value=%0d consumed=%0d",
                                value_i, consumed_i));
      return;
    end
    want = parsed_q.pop_front();
    if (value_i !== want.value) begin
      report_mismatch($sformatf("value %0d, want %0d", value_i, $signed(want.value)));
    end
    if (consumed_i !== want.consumed) begin
      report_mismatch($sformatf("consumed %0d, want %0d", consumed_i, want.consumed));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix = '0;
      clear_parse();
      parsed_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) radix = cfg_data_i;
      if (in_valid_i && in_ready_i) parse_char(ch_i, start_req_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    pending_o = parsed_q.size();
  end

endmodule

// ===== test/ascii_integer_parser_tb.sv =====
module ascii_integer_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime     ClkPeriod   = 2.0;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned CycleLimit  = 1_000_000;
  // long enough to pin the magnitude at saturation
  localparam int unsigned LongDigits  = 100;
  // receiver hold-off, well past what the input and output stages can buffer
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned PhaseItems  = 60;
  localparam int unsigned PressureStrings = 40;
  // from transfer to result, a character passes the input and result registers
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned EndCycles    = 8;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [aip_pkg::BaseW-1:0]        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       ch = '0;
  logic                             start_req = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [aip_pkg::ValW-1:0]  value;
  logic [aip_pkg::CntW-1:0]         consumed;

  int fails;
  int pending;

  // stimulus state; only quiet and hold_req are shared with the result sink
  bit quiet = 1'b0;          // no idling at all on either side
  bit hold_req = 1'b0;       // asks the sink for one long hold-off
  bit sender_busy = 1'b0;    // current sender stretch idles now and then
  int unsigned sender_left = 0;
  int unsigned items_sent = 0;
  logic [aip_pkg::BaseW-1:0] cur_radix = '0;

  always #(ClkPeriod / 2) clk = ~clk;

  ascii_integer_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .ch_i        (ch),
    .start_req_i (start_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .value_o     (value),
    .consumed_o  (consumed)
  );

  ascii_integer_parser_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .ch_i         (ch),
    .start_req_i  (start_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .value_i      (value),
    .consumed_i   (consumed),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // Digit character for value v; letters come in either case at random.
  function automatic logic [7:0] digit_char(int unsigned v);
    logic [7:0] letter_a;
    letter_a = $urandom_range(0, 1) ? "a" : "A";
    return (v < 10) ? "0" + 8'(v) : letter_a + 8'(v - 10);
  endfunction

  // Any byte that is neither a decimal digit nor a letter.
  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
    return c;
  endfunction

  // One character transfer. The sender works in stretches of items: in a busy
  // stretch it drops valid for a random burst before some items, in a calm
  // stretch it never does. Valid is only ever lowered here or by settle(), so
  // no signal sees two nonblocking writes in one step.
  task automatic send_item(logic [7:0] c, logic s);
    if (sender_left == 0) begin
      sender_left = $urandom_range(10, 80);
      sender_busy = $urandom_range(0, 1);
    end
    sender_left--;
    if (!quiet && sender_busy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    ch        <= c;
    start_req <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(string s, logic first_start);
    for (int i = 0; i < s.len(); i++) send_item(s[i], first_start && i == 0);
  endtask

  // Stop offering characters, wait for every pending result, then give the
  // pipeline time to swallow characters that produce nothing. A clock wait
  // first lets the checker count the last transfer before pending is looked at.
  task automatic settle(int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (tail) @(posedge clk);
  endtask

  // Radix register write, only with the parser idle.
  task automatic write_radix(logic [aip_pkg::BaseW-1:0] r);
    settle(SettleCycles);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_radix = r;
  endtask

  // Mostly a well-formed number under the current radix (optional sign,
  // optional prefix in auto mode, digits below the base, then a stop
  // character); about one in five is a burst of random bytes and starts.
  task automatic send_string();
    logic [7:0]  text[$];
    int unsigned base;
    int unsigned hi;
    int unsigned n;
    int unsigned v;
    logic        first_start;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send_item(8'($urandom), $urandom_range(0, 3) == 0);
      items_sent += n;
      return;
    end
    if ($urandom_range(0, 1)) text.push_back("-");
    base = cur_radix;
    if (cur_radix == '0) begin
      case ($urandom_range(0, 3))
        0: begin
          text.push_back("0");
          text.push_back($urandom_range(0, 1) ? "x" : "X");
          base = 16;
        end
        1: begin
          text.push_back("0");
          base = 8;
        end
        default: begin
          base = 10;
        end
      endcase
    end
    // bases above 36 accept every letter; radix 1 only takes '0'
    hi = (base > 36) ? 35 : base - 1;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 10);
    for (int k = 0; k < n; k++) begin
      v = $urandom_range(0, hi);
      // a leading zero would switch auto mode to octal
      if (cur_radix == '0 && base == 10 && k == 0 && v == 0) v = 1;
      text.push_back(digit_char(v));
    end
    case ($urandom_range(0, 2))
      0: text.push_back((base < 36) ? digit_char($urandom_range(base, 35)) : stray_char());
      1: text.push_back(8'($urandom_range(128, 255)));
      default: text.push_back(stray_char());
    endcase
    // now and then no start: the string lands on whatever state is left
    first_start = ($urandom_range(0, 9) != 0);
    foreach (text[i]) send_item(text[i], first_start && i == 0);
    items_sent += text.size();
    // trailing bytes after the stop are ignored and not counted as items
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
    end
  endtask

  // Result sink. Ready follows its own stretches of idle bursts, plus one
  // long hold-off on request, counted here in cycles while the source keeps
  // pushing characters so the parser fills up and drops in_ready.
  initial begin
    int unsigned recv_left;
    bit          recv_busy;
    recv_left = 0;
    recv_busy = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int k = 1; k < HoldCycles; k++) @(posedge clk);
      end else begin
        if (recv_left == 0) begin
          recv_left = $urandom_range(20, 150);
          recv_busy = $urandom_range(0, 1);
        end
        recv_left--;
        if (!quiet && recv_busy && $urandom_range(0, 4) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 14) - 1) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run here.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ascii_integer_parser_tb: FAIL");
    $finish;
  end

  initial begin
    logic [aip_pkg::BaseW-1:0] radix_plan[$];
    string                     boundary_texts[$];
    int unsigned               target;
    boundary_texts = '{"2147483647,", "2147483648,", "-2147483647,", "-2147483648,",
                       "-2147483646,", "0x7fffffff,", "-0X80000000,", "017777777777,",
                       "020000000000,", "-0x0,"};
    // extremes (0, 1, 36, 63) and the common bases; the last two run without idling
    radix_plan = {6'd10, 6'd16, 6'd0, 6'd8, 6'd2, 6'd1, 6'd36, 6'd37, 6'd63,
                  6'($urandom_range(0, 63)), 6'd0, 6'd36};

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, radix still at its reset value (auto-detect).
    send_text("-,", 1'b0);          // no start after reset; sign without digits
    send_text("0Xg", 1'b1);         // hex prefix without digits
    send_text("-0,", 1'b1);         // negative zero via octal prefix
    send_text("-078z", 1'b1);       // octal stops at '8'; 'z' after result ignored
    send_text("12", 1'b1);
    send_item("9", 1'b1);           // start in the middle of a number
    send_item(8'hFF, 1'b0);         // top byte stops the number
    send_text("0", 1'b1);
    send_item(8'h00, 1'b0);         // lone zero prefix, stopped by NUL
    write_radix(6'd36);
    send_text("-Zzzzzzz.", 1'b1);   // saturates to the most negative value

    // Random part, one phase per radix setting.
    foreach (radix_plan[p]) begin
      quiet = (p >= radix_plan.size() - 2);
      write_radix(radix_plan[p]);
      case (p)
        0: begin
          // one long number that runs well into magnitude saturation
          quiet = 1'b1;
          send_item("-", 1'b1);
          repeat (LongDigits) send_item("9", 1'b0);
          send_item(".", 1'b0);
          quiet = 1'b0;
        end
        1: begin
          // sink stalls for a long stretch while short numbers keep coming,
          // then the source waits for every result before going on
          hold_req = 1'b1;
          repeat (PressureStrings) begin
            send_item(digit_char($urandom_range(0, 15)), 1'b1);
            send_item(",", 1'b0);
          end
          settle(SettleCycles);
        end
        2: begin
          // saturation boundaries in every prefix mode
          foreach (boundary_texts[i]) send_text(boundary_texts[i], 1'b1);
        end
        default: begin
        end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) send_string();
    end

    settle(EndCycles);
    if (fails == 0 && pending == 0) begin
      $display("ascii_integer_parser_tb: PASS");
    end else begin
      $display("ascii_integer_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== ascii_integer_parser.f =====
+incdir+src
src/aip_pkg.sv
src/aip_core.sv
src/aip_out_reg.sv
src/ascii_integer_parser.sv
test/ascii_integer_parser_checker.sv
test/ascii_integer_parser_tb.sv
